// ===== rtl/amx_pkg.sv =====
// Shared types, constants and helpers of the affine 3x4 matrix inverse.
package amx_pkg;

  localparam int unsigned QW     = 32;          // Q16.16 element
  localparam int unsigned PW     = 48;          // floored product of two elements
  localparam int unsigned CW     = 49;          // cofactor
  localparam int unsigned TW     = 81;          // element times cofactor
  localparam int unsigned DW     = 83;          // determinant, 32 fraction bits
  localparam int unsigned RW     = DW + 1;      // divider remainder
  localparam int unsigned SW     = 51;          // negated translation sum
  localparam int unsigned NSTEPS = 32;          // quotient bits per division
  localparam int unsigned CNTW   = $clog2(NSTEPS);
  localparam int unsigned NSTAGE = 6;           // front pipeline depth
  localparam int unsigned QDEPTH = 2;           // job queue depth
  localparam int unsigned QPTRW  = $clog2(QDEPTH);

  // Element indices (row * 4 + column) of a*b - c*d for each cofactor.
  localparam int unsigned COF_IDX [9][4] = '{
    '{5, 10, 9, 6},
    '{9, 2, 1, 10},
    '{1, 6, 5, 2},
    '{8, 6, 4, 10},
    '{0, 10, 8, 2},
    '{4, 2, 0, 6},
    '{4, 9, 8, 5},
    '{8, 1, 0, 9},
    '{0, 5, 4, 1}
  };

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PW-1:0] p_t;
  typedef logic signed [CW-1:0] cof_t;

  // Divider control of the back end.
  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} div_state_e;

  typedef struct packed {
    q_t in_r0c0;
    q_t in_r0c1;
    q_t in_r0c2;
    q_t in_r0c3;
    q_t in_r1c0;
    q_t in_r1c1;
    q_t in_r1c2;
    q_t in_r1c3;
    q_t in_r2c0;
    q_t in_r2c1;
    q_t in_r2c2;
    q_t in_r2c3;
  } in_t;

  typedef struct packed {
    q_t out_r0c0;
    q_t out_r0c1;
    q_t out_r0c2;
    q_t out_r0c3;
    q_t out_r1c0;
    q_t out_r1c1;
    q_t out_r1c2;
    q_t out_r1c3;
    q_t out_r2c0;
    q_t out_r2c1;
    q_t out_r2c2;
    q_t out_r2c3;
  } out_t;

  // One classified transform handed from front to back.
  typedef struct packed {
    q_t   [2:0]    tcol;
    cof_t [8:0]    cof;
    logic          det_zero;
    logic          det_neg;
    logic [DW-1:0] det_mag;
  } job_t;

  // Product of two elements shifted right by 16, rounding toward minus infinity.
  function automatic p_t floor_mul(input q_t a, input q_t b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return p[2*QW-1:16];
  endfunction

  // Clamp the wide translation sum to the Q16.16 range.
  function automatic q_t sat_q(input logic signed [SW-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[SW-1:QW-1];
    hi_zeros = ~|x[SW-1:QW-1];
    if (hi_ones || hi_zeros) begin
      return x[QW-1:0];
    end
    return x[SW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  endfunction

endpackage

// ===== rtl/amx_front.sv =====
// Front pipeline: cofactors, determinant and its sign and magnitude.
module amx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  amx_pkg::in_t  in_data_i,
  output logic          push_o,
  output amx_pkg::job_t job_o,
  input  logic          full_i
);

  logic [amx_pkg::NSTAGE-1:0] v_q, v_d;
  logic en;

  amx_pkg::q_t m [12];

  amx_pkg::p_t   pf_q   [18];
  amx_pkg::q_t   t1_q   [3];
  amx_pkg::q_t   c1_q   [3];
  amx_pkg::cof_t cof2_q [9];
  amx_pkg::q_t   t2_q   [3];
  amx_pkg::q_t   c2_q   [3];
  logic signed [2*amx_pkg::QW:0]             pl3_q [3];
  logic signed [amx_pkg::CW-1:0]             ph3_q [3];
  amx_pkg::cof_t cof3_q [9];
  amx_pkg::q_t   t3_q   [3];
  logic signed [amx_pkg::TW-1:0]             term4_q [3];
  amx_pkg::cof_t cof4_q [9];
  amx_pkg::q_t   t4_q   [3];
  logic signed [amx_pkg::DW-1:0]             det5_q;
  amx_pkg::cof_t cof5_q [9];
  amx_pkg::q_t   t5_q   [3];
  amx_pkg::job_t job_q;

  assign m[0]  = in_data_i.in_r0c0;
  assign m[1]  = in_data_i.in_r0c1;
  assign m[2]  = in_data_i.in_r0c2;
  assign m[3]  = in_data_i.in_r0c3;
  assign m[4]  = in_data_i.in_r1c0;
  assign m[5]  = in_data_i.in_r1c1;
  assign m[6]  = in_data_i.in_r1c2;
  assign m[7]  = in_data_i.in_r1c3;
  assign m[8]  = in_data_i.in_r2c0;
  assign m[9]  = in_data_i.in_r2c1;
  assign m[10] = in_data_i.in_r2c2;
  assign m[11] = in_data_i.in_r2c3;

  // Advance the whole pipeline unless the last beat cannot enter the queue.
  assign en         = !(v_q[amx_pkg::NSTAGE-1] && full_i);
  assign in_stall_o = !en;
  assign push_o     = v_q[amx_pkg::NSTAGE-1] && !full_i;
  assign job_o      = job_q;

  always_comb begin
    v_d = {v_q[amx_pkg::NSTAGE-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pf_q[2*k]   <= amx_pkg::floor_mul(m[amx_pkg::COF_IDX[k][0]], m[amx_pkg::COF_IDX[k][1]]);
        pf_q[2*k+1] <= amx_pkg::floor_mul(m[amx_pkg::COF_IDX[k][2]], m[amx_pkg::COF_IDX[k][3]]);
      end
      for (int r = 0; r < 3; r++) begin
        t1_q[r] <= m[4*r+3];
        c1_q[r] <= m[4*r];
      end

      for (int k = 0; k < 9; k++) begin
        cof2_q[k] <= amx_pkg::CW'(pf_q[2*k]) - amx_pkg::CW'(pf_q[2*k+1]);
      end
      t2_q <= t1_q;
      c2_q <= c1_q;

      // Split each cofactor into an unsigned low word and a signed high part.
      for (int r = 0; r < 3; r++) begin
        pl3_q[r] <= c2_q[r] * $signed({1'b0, cof2_q[r][amx_pkg::QW-1:0]});
        ph3_q[r] <= c2_q[r] * $signed(cof2_q[r][amx_pkg::CW-1:amx_pkg::QW]);
      end
      cof3_q <= cof2_q;
      t3_q   <= t2_q;

      for (int r = 0; r < 3; r++) begin
        term4_q[r] <= $signed({ph3_q[r], {amx_pkg::QW{1'b0}}}) + amx_pkg::TW'(pl3_q[r]);
      end
      cof4_q <= cof3_q;
      t4_q   <= t3_q;

      det5_q <= amx_pkg::DW'(term4_q[0]) + amx_pkg::DW'(term4_q[1])
              + amx_pkg::DW'(term4_q[2]);
      cof5_q <= cof4_q;
      t5_q   <= t4_q;

      job_q.det_zero <= (det5_q == '0);
      job_q.det_neg  <= det5_q[amx_pkg::DW-1];
      job_q.det_mag  <= det5_q[amx_pkg::DW-1] ? amx_pkg::DW'(-det5_q)
                                              : amx_pkg::DW'(det5_q);
      for (int k = 0; k < 9; k++) begin
        job_q.cof[k] <= cof5_q[k];
      end
      for (int r = 0; r < 3; r++) begin
        job_q.tcol[r] <= t5_q[r];
      end
    end
  end

endmodule

// ===== rtl/amx_queue.sv =====
// Two-entry queue of classified jobs between front and back.
module amx_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  amx_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          avail_o,
  output amx_pkg::job_t job_o
);

  amx_pkg::job_t mem_q [amx_pkg::QDEPTH];
  logic [amx_pkg::QPTRW-1:0] wr_q, rd_q;
  logic [amx_pkg::QPTRW:0]   cnt_q;

  assign full_o  = (cnt_q == (amx_pkg::QPTRW+1)'(amx_pkg::QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/amx_back.sv =====
// Back end: nine radix-2 divider lanes, translation products, output register.
module amx_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  amx_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output amx_pkg::out_t out_data_o
);

  amx_pkg::div_state_e state_q, state_d;
  logic [amx_pkg::CNTW-1:0] cnt_q;

  logic [amx_pkg::RW-1:0] rem_q [9];
  logic [amx_pkg::QW-1:0] quo_q [9];
  logic [8:0]             big_q, neg_q;
  logic [amx_pkg::DW-1:0] den_q;
  logic                   dz_q;
  amx_pkg::q_t            t_q [3];

  logic        mv_q, dzm_q;
  amx_pkg::q_t r_q  [9];
  amx_pkg::p_t pr_q [9];

  logic         ov_q;
  amx_pkg::out_t out_q;

  logic out_load, mul_free, handoff, last_step;
  amx_pkg::q_t lane_res [9];
  amx_pkg::q_t res [12];

  function automatic amx_pkg::q_t div_sat(input logic [amx_pkg::QW-1:0] q,
                                          input logic big, input logic neg);
    if (!neg) begin
      return (big || q[amx_pkg::QW-1]) ? {1'b0, {(amx_pkg::QW-1){1'b1}}} : q;
    end
    if (big || (q > {1'b1, {(amx_pkg::QW-1){1'b0}}})) begin
      return {1'b1, {(amx_pkg::QW-1){1'b0}}};
    end
    return -q;
  endfunction

  assign out_load  = !ov_q || !out_stall_i;
  assign mul_free  = !mv_q || out_load;
  assign last_step = (cnt_q == amx_pkg::CNTW'(amx_pkg::NSTEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      amx_pkg::DIV_IDLE: begin
        if (avail_i) state_d = amx_pkg::DIV_RUN;
      end
      amx_pkg::DIV_RUN: begin
        if (last_step) state_d = amx_pkg::DIV_DONE;
      end
      amx_pkg::DIV_DONE: begin
        if (mul_free) state_d = avail_i ? amx_pkg::DIV_RUN : amx_pkg::DIV_IDLE;
      end
      default: state_d = amx_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    handoff = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      amx_pkg::DIV_IDLE: pop_o = avail_i;
      amx_pkg::DIV_DONE: begin
        handoff = mul_free;
        pop_o   = avail_i && mul_free;
      end
      default: begin
        handoff = 1'b0;
        pop_o   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amx_pkg::DIV_IDLE;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == amx_pkg::DIV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (handoff) begin
        mv_q <= 1'b1;
      end else if (out_load) begin
        mv_q <= 1'b0;
      end
      if (out_load) begin
        ov_q <= mv_q;
      end
    end
  end

  // Divider lanes: load the cofactor magnitude, then one quotient bit a cycle.
  always_ff @(posedge clk_i) begin
    logic [amx_pkg::CW-1:0] a;
    logic [amx_pkg::RW-1:0] r2;
    logic                   ge;
    if (pop_o) begin
      den_q <= job_i.det_mag;
      dz_q  <= job_i.det_zero;
      for (int r = 0; r < 3; r++) begin
        t_q[r] <= $signed(job_i.tcol[r]);
      end
      for (int k = 0; k < 9; k++) begin
        a = job_i.cof[k][amx_pkg::CW-1] ? amx_pkg::CW'(-$signed(job_i.cof[k]))
                                        : amx_pkg::CW'(job_i.cof[k]);
        rem_q[k] <= amx_pkg::RW'(a);
        quo_q[k] <= '0;
        big_q[k] <= (amx_pkg::DW'(a) >= job_i.det_mag);
        neg_q[k] <= job_i.cof[k][amx_pkg::CW-1] ^ job_i.det_neg;
      end
    end else if (state_q == amx_pkg::DIV_RUN) begin
      for (int k = 0; k < 9; k++) begin
        r2 = {rem_q[k][amx_pkg::RW-2:0], 1'b0};
        ge = (r2 >= amx_pkg::RW'(den_q));
        rem_q[k] <= ge ? (r2 - amx_pkg::RW'(den_q)) : r2;
        quo_q[k] <= {quo_q[k][amx_pkg::QW-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      lane_res[k] = div_sat(quo_q[k], big_q[k], neg_q[k]);
    end
  end

  // Translation products of the saturated linear part.
  always_ff @(posedge clk_i) begin
    if (handoff) begin
      dzm_q <= dz_q;
      for (int k = 0; k < 9; k++) begin
        r_q[k]  <= lane_res[k];
        pr_q[k] <= amx_pkg::floor_mul(t_q[k % 3], lane_res[k]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        res[4*i+j] = dzm_q ? '0 : r_q[3*i+j];
      end
      res[4*i+3] = dzm_q ? '0 : amx_pkg::sat_q(-(amx_pkg::SW'(pr_q[3*i])
                           + amx_pkg::SW'(pr_q[3*i+1]) + amx_pkg::SW'(pr_q[3*i+2])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && mv_q) begin
      out_q.out_r0c0 <= res[0];
      out_q.out_r0c1 <= res[1];
      out_q.out_r0c2 <= res[2];
      out_q.out_r0c3 <= res[3];
      out_q.out_r1c0 <= res[4];
      out_q.out_r1c1 <= res[5];
      out_q.out_r1c2 <= res[6];
      out_q.out_r1c3 <= res[7];
      out_q.out_r2c0 <= res[8];
      out_q.out_r2c1 <= res[9];
      out_q.out_r2c2 <= res[10];
      out_q.out_r2c3 <= res[11];
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/affine_matrix_inverse.sv =====
// Top level of the affine 3x4 matrix inverse: front pipeline, job queue, back end.
//
// Takes one 3x4 affine transform per beat as twelve signed Q16.16 values and
// returns its inverse as one beat. The front pipeline accepts a beat every
// cycle while in_stall_o is low and forms the cofactors and the determinant;
// a two-entry queue then feeds the back end, where nine divider lanes work
// together on one transform, one quotient bit per lane per cycle. The shared
// divider sets the sustained rate: it takes a new transform only once it is
// through with the last, with the front and queue absorbing bursts of up to
// nine beats before in_stall_o rises. A zero determinant gives an all-zero
// result; every element that falls outside Q16.16 is saturated.
module affine_matrix_inverse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  amx_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output amx_pkg::out_t out_data_o
);

  logic          push, full, pop, avail;
  amx_pkg::job_t job_in, job_out;

  // Classify: cofactors, determinant sign and magnitude.
  amx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  // Hold jobs so either side may stall on its own.
  amx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .job_o   (job_out)
  );

  // Divide, form the new translation, register the result beat.
  amx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
